// File: design/smms_pkg.sv
// ----------------------------------------------------------------------------
// smms_pkg
// Shared types and constants of the stepper motion mode sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package smms_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned TICK_W  = 17;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    localparam logic [TIME_W-1:0] MOVE_TIMEOUT_RST   = 16'd30000;
    localparam logic [TIME_W-1:0] HOMING_TIMEOUT_RST = 16'd60000;
    localparam logic [TIME_W-1:0] STOP_TIMEOUT_RST   = 16'd5000;
    localparam logic [TIME_W-1:0] TOLERANCE_RST      = 16'd5;
    localparam logic [TIME_W-1:0] THRESHOLD_RST      = 16'd10;
    localparam logic [1:0]        HOMING_MODE_RST    = 2'd0;
    localparam logic [1:0]        HOMING_VIRTUAL     = 2'd0;

    // Input item kinds
    typedef enum logic [3:0] {
        ACT_TICK     = 4'd0,
        ACT_ENABLE   = 4'd1,
        ACT_DISABLE  = 4'd2,
        ACT_MOVE     = 4'd3,
        ACT_STOP     = 4'd4,
        ACT_ESTOP    = 4'd5,
        ACT_HOME     = 4'd6,
        ACT_RUN      = 4'd7,
        ACT_RELEASE  = 4'd8,
        ACT_RESTART  = 4'd9,
        ACT_SET_ZERO = 4'd10,
        ACT_ENCODER  = 4'd11,
        ACT_SPEED    = 4'd12,
        ACT_STATUS   = 4'd13,
        ACT_PROTECT  = 4'd14,
        ACT_XPORT    = 4'd15
    } smms_act_t;

    // Drive command codes
    typedef enum logic [3:0] {
        DRV_NONE     = 4'd0,
        DRV_ENABLE   = 4'd1,
        DRV_DISABLE  = 4'd2,
        DRV_MOVE     = 4'd3,
        DRV_STOP     = 4'd4,
        DRV_ESTOP    = 4'd5,
        DRV_ZERO     = 4'd6,
        DRV_RESTART  = 4'd7,
        DRV_RUN      = 4'd8,
        DRV_RELEASE  = 4'd9,
        DRV_SET_ZERO = 4'd10
    } smms_drv_t;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_MOVE_TIMEOUT   = 3'd0,
        REG_HOMING_TIMEOUT = 3'd1,
        REG_STOP_TIMEOUT   = 3'd2,
        REG_TOLERANCE      = 3'd3,
        REG_THRESHOLD      = 3'd4,
        REG_HOMING_MODE    = 3'd5
    } smms_reg_t;

    typedef struct packed {
        logic [TIME_W-1:0] move_timeout;
        logic [TIME_W-1:0] homing_timeout;
        logic [TIME_W-1:0] stop_timeout;
        logic [TIME_W-1:0] tolerance;
        logic [TIME_W-1:0] threshold;
        logic [1:0]        homing_mode;
    } smms_cfg_t;

    // Classified item as it travels through the queue
    typedef struct packed {
        smms_act_t                act;
        logic signed [POS_W-1:0]  pos;
        logic signed [SPEED_W-1:0] speed;
        logic                     flag;
    } smms_op_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       accepted;
        smms_drv_t  drive_command;
        logic       clear_queue;
        logic       position_moved;
        logic       speed_changed;
        logic       status_changed;
        logic       motor_running;
        logic       protection_event;
        logic       last;
    } smms_res_t;

endpackage

`default_nettype wire

// File: design/smms_if.sv
// ----------------------------------------------------------------------------
// smms_event_if / smms_result_if
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface smms_event_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic signed [31:0] target_position;
    logic signed [31:0] measured_position;
    logic signed [15:0] measured_speed;
    logic        report_flag;
    logic        error_kind;
    logic        critical_command;

    modport source (
        output valid, action, target_position, measured_position, measured_speed,
               report_flag, error_kind, critical_command,
        input  ready
    );
    modport sink (
        input  valid, action, target_position, measured_position, measured_speed,
               report_flag, error_kind, critical_command,
        output ready
    );
endinterface

interface smms_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic       accepted;
    logic [3:0] drive_command;
    logic       clear_queue;
    logic       position_moved;
    logic       speed_changed;
    logic       status_changed;
    logic       motor_running;
    logic       protection_event;
    logic       last;

    modport source (
        output valid, mode, accepted, drive_command, clear_queue, position_moved,
               speed_changed, status_changed, motor_running, protection_event, last,
        input  ready
    );
    modport sink (
        input  valid, mode, accepted, drive_command, clear_queue, position_moved,
               speed_changed, status_changed, motor_running, protection_event, last,
        output ready
    );
endinterface

`default_nettype wire

// File: design/smms_regs.sv
// ----------------------------------------------------------------------------
// smms_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module smms_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [smms_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [smms_pkg::DATA_W-1:0]   pwdata,
    output logic      [smms_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output smms_pkg::smms_cfg_t                cfg
);

    smms_pkg::smms_cfg_t cfg_reg;
    smms_pkg::smms_reg_t reg_idx;
    logic                wr_en;

    assign reg_idx = smms_pkg::smms_reg_t'(paddr[smms_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_timeout   <= smms_pkg::MOVE_TIMEOUT_RST;
            cfg_reg.homing_timeout <= smms_pkg::HOMING_TIMEOUT_RST;
            cfg_reg.stop_timeout   <= smms_pkg::STOP_TIMEOUT_RST;
            cfg_reg.tolerance      <= smms_pkg::TOLERANCE_RST;
            cfg_reg.threshold      <= smms_pkg::THRESHOLD_RST;
            cfg_reg.homing_mode    <= smms_pkg::HOMING_MODE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                smms_pkg::REG_MOVE_TIMEOUT:   cfg_reg.move_timeout   <= pwdata[15:0];
                smms_pkg::REG_HOMING_TIMEOUT: cfg_reg.homing_timeout <= pwdata[15:0];
                smms_pkg::REG_STOP_TIMEOUT:   cfg_reg.stop_timeout   <= pwdata[15:0];
                smms_pkg::REG_TOLERANCE:      cfg_reg.tolerance      <= pwdata[15:0];
                smms_pkg::REG_THRESHOLD:      cfg_reg.threshold      <= pwdata[15:0];
                smms_pkg::REG_HOMING_MODE:    cfg_reg.homing_mode    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            smms_pkg::REG_MOVE_TIMEOUT:   prdata = {16'd0, cfg_reg.move_timeout};
            smms_pkg::REG_HOMING_TIMEOUT: prdata = {16'd0, cfg_reg.homing_timeout};
            smms_pkg::REG_STOP_TIMEOUT:   prdata = {16'd0, cfg_reg.stop_timeout};
            smms_pkg::REG_TOLERANCE:      prdata = {16'd0, cfg_reg.tolerance};
            smms_pkg::REG_THRESHOLD:      prdata = {16'd0, cfg_reg.threshold};
            smms_pkg::REG_HOMING_MODE:    prdata = {30'd0, cfg_reg.homing_mode};
            default:                      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: design/smms_front.sv
// ----------------------------------------------------------------------------
// smms_front
// Accept input items and classify them into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module smms_front (
    smms_event_if.sink               event_ch,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output smms_pkg::smms_op_t       push_op
);

    smms_pkg::smms_act_t act;

    assign act            = smms_pkg::smms_act_t'(event_ch.action);
    assign push_valid     = event_ch.valid;
    assign event_ch.ready = push_ready;

    // Fold the payload down to the one position and one flag the back end needs
    always_comb
    begin
        push_op.act   = act;
        push_op.speed = event_ch.measured_speed;
        if (act == smms_pkg::ACT_ENCODER)
        begin
            push_op.pos = event_ch.measured_position;
        end
        else
        begin
            push_op.pos = event_ch.target_position;
        end
        if (act == smms_pkg::ACT_XPORT)
        begin
            push_op.flag = event_ch.error_kind | event_ch.critical_command;
        end
        else
        begin
            push_op.flag = event_ch.report_flag;
        end
    end

endmodule

`default_nettype wire

// File: design/smms_queue.sv
// ----------------------------------------------------------------------------
// smms_queue
// Two-entry queue of classified items between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module smms_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  smms_pkg::smms_op_t       push_op,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output smms_pkg::smms_op_t       pop_op
);

    smms_pkg::smms_op_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// File: design/smms_back.sv
// ----------------------------------------------------------------------------
// smms_back
// Execute queued items against the motion mode and emit result items.
// ----------------------------------------------------------------------------
`default_nettype none

module smms_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  smms_pkg::smms_cfg_t      cfg,
    input  wire logic                op_valid,
    output logic                     op_ready,
    input  smms_pkg::smms_op_t       op,
    smms_result_if.source            result_ch
);

    typedef enum logic [2:0] {
        MODE_DISABLED = 3'd0,
        MODE_IDLE     = 3'd1,
        MODE_MOVING   = 3'd2,
        MODE_RUNNING  = 3'd3,
        MODE_HOMING   = 3'd4,
        MODE_STOPPING = 3'd5,
        MODE_ERROR    = 3'd6
    } mode_t;

    typedef struct packed {
        mode_t                                   mode;
        logic [smms_pkg::TICK_W-1:0]             elapsed;
        logic signed [smms_pkg::POS_W-1:0]       target;
        logic signed [smms_pkg::POS_W-1:0]       cur;
        logic signed [smms_pkg::SPEED_W-1:0]     speed;
        logic                                    run;
        logic                                    prot;
        logic                                    emer;
        logic                                    dbuf;
    } state_t;

    state_t              st_reg;
    state_t              st_next;
    smms_pkg::smms_res_t out_reg;
    logic                out_valid_reg;
    smms_pkg::smms_res_t pend_reg;
    logic                pend_valid_reg;

    smms_pkg::smms_res_t first_res;
    smms_pkg::smms_res_t second_res;
    logic                two_res;
    logic                take;
    logic                slot_free;

    logic [smms_pkg::TICK_W-1:0] tick_inc;
    logic signed [smms_pkg::POS_W:0] tgt_diff;
    logic signed [smms_pkg::POS_W:0] step_diff;
    logic [smms_pkg::POS_W:0]        tgt_dist;
    logic [smms_pkg::POS_W:0]        step_dist;

    function automatic state_t go_to(state_t s, mode_t m);
        state_t r;
        r = s;
        if (m != s.mode)
        begin
            r.mode    = m;
            r.elapsed = '0;
            if (m == MODE_IDLE)
            begin
                r.target = s.cur;
            end
        end
        return r;
    endfunction

    function automatic logic in_motion(mode_t m);
        return (m == MODE_MOVING) || (m == MODE_RUNNING) ||
               (m == MODE_HOMING) || (m == MODE_STOPPING);
    endfunction

    assign slot_free = !out_valid_reg || result_ch.ready;
    assign take      = op_valid && !pend_valid_reg && slot_free;
    assign op_ready  = !pend_valid_reg && slot_free;

    // Saturating tick count and the two encoder distances
    assign tick_inc  = (&st_reg.elapsed) ? st_reg.elapsed
                                         : st_reg.elapsed + 1'b1;
    assign tgt_diff  = {op.pos[smms_pkg::POS_W-1], op.pos}
                     - {st_reg.target[smms_pkg::POS_W-1], st_reg.target};
    assign step_diff = {op.pos[smms_pkg::POS_W-1], op.pos}
                     - {st_reg.cur[smms_pkg::POS_W-1], st_reg.cur};
    assign tgt_dist  = tgt_diff[smms_pkg::POS_W]  ? $unsigned(-tgt_diff)
                                                  : $unsigned(tgt_diff);
    assign step_dist = step_diff[smms_pkg::POS_W] ? $unsigned(-step_diff)
                                                  : $unsigned(step_diff);

    always_comb
    begin
        state_t             s;
        logic               acc;
        logic               clr;
        logic               moved;
        logic               spd_chg;
        logic               stat_chg;
        logic               prot_evt;
        smms_pkg::smms_drv_t cmd0;
        smms_pkg::smms_drv_t cmd1;

        s        = st_reg;
        acc      = 1'b0;
        clr      = 1'b0;
        moved    = 1'b0;
        spd_chg  = 1'b0;
        stat_chg = 1'b0;
        prot_evt = 1'b0;
        cmd0     = smms_pkg::DRV_NONE;
        cmd1     = smms_pkg::DRV_NONE;
        two_res  = 1'b0;

        case (op.act)
            smms_pkg::ACT_TICK:
            begin
                s.elapsed = tick_inc;
                if (s.mode == MODE_MOVING && tick_inc > {1'b0, cfg.move_timeout})
                begin
                    clr = 1'b1;
                    s   = go_to(s, MODE_ERROR);
                end
                else if (s.mode == MODE_HOMING &&
                         tick_inc > {1'b0, cfg.homing_timeout})
                begin
                    clr = 1'b1;
                    s   = go_to(s, MODE_ERROR);
                end
                else if (s.mode == MODE_STOPPING &&
                         tick_inc > {1'b0, cfg.stop_timeout})
                begin
                    s = go_to(s, MODE_IDLE);
                end
                // Carry out a disable held back during motion
                if (s.dbuf && s.mode == MODE_IDLE)
                begin
                    s.dbuf = 1'b0;
                    cmd0   = smms_pkg::DRV_DISABLE;
                    s      = go_to(s, MODE_DISABLED);
                end
            end
            smms_pkg::ACT_ENABLE:
            begin
                if (s.mode == MODE_DISABLED)
                begin
                    acc  = 1'b1;
                    cmd0 = smms_pkg::DRV_ENABLE;
                    s    = go_to(s, MODE_IDLE);
                end
            end
            smms_pkg::ACT_DISABLE:
            begin
                if (in_motion(s.mode))
                begin
                    s.dbuf = 1'b1;
                    acc    = 1'b1;
                    cmd0   = smms_pkg::DRV_STOP;
                    s      = go_to(s, MODE_STOPPING);
                end
                else if (s.mode == MODE_IDLE || s.mode == MODE_ERROR)
                begin
                    acc  = 1'b1;
                    cmd0 = smms_pkg::DRV_DISABLE;
                    s    = go_to(s, MODE_DISABLED);
                end
            end
            smms_pkg::ACT_MOVE:
            begin
                if (s.mode == MODE_IDLE || s.mode == MODE_MOVING ||
                    s.mode == MODE_STOPPING)
                begin
                    acc      = 1'b1;
                    s.target = op.pos;
                    cmd0     = smms_pkg::DRV_MOVE;
                    if (s.mode == MODE_IDLE)
                    begin
                        s = go_to(s, MODE_MOVING);
                    end
                end
            end
            smms_pkg::ACT_STOP:
            begin
                if (s.mode == MODE_IDLE)
                begin
                    acc = 1'b1;
                end
                else if (in_motion(s.mode))
                begin
                    acc  = 1'b1;
                    cmd0 = smms_pkg::DRV_STOP;
                    s    = go_to(s, MODE_STOPPING);
                end
            end
            smms_pkg::ACT_ESTOP:
            begin
                acc     = 1'b1;
                s.emer  = 1'b1;
                clr     = 1'b1;
                cmd0    = smms_pkg::DRV_ESTOP;
                cmd1    = smms_pkg::DRV_DISABLE;
                two_res = 1'b1;
                s       = go_to(s, MODE_ERROR);
            end
            smms_pkg::ACT_HOME:
            begin
                if (s.mode == MODE_IDLE && cfg.homing_mode == smms_pkg::HOMING_VIRTUAL)
                begin
                    acc     = 1'b1;
                    cmd0    = smms_pkg::DRV_ZERO;
                    cmd1    = smms_pkg::DRV_RESTART;
                    two_res = 1'b1;
                    s       = go_to(s, MODE_HOMING);
                end
            end
            smms_pkg::ACT_RUN:
            begin
                if (s.mode == MODE_IDLE || s.mode == MODE_RUNNING)
                begin
                    acc  = 1'b1;
                    cmd0 = smms_pkg::DRV_RUN;
                    s    = go_to(s, MODE_RUNNING);
                end
            end
            smms_pkg::ACT_RELEASE:
            begin
                if (s.mode == MODE_ERROR || s.mode == MODE_IDLE ||
                    s.mode == MODE_DISABLED)
                begin
                    acc = 1'b1;
                    if (s.prot || s.emer)
                    begin
                        s.prot = 1'b0;
                        s.emer = 1'b0;
                        cmd0   = smms_pkg::DRV_RELEASE;
                        if (s.mode == MODE_ERROR)
                        begin
                            s = go_to(s, MODE_IDLE);
                        end
                    end
                end
            end
            smms_pkg::ACT_RESTART:
            begin
                acc    = 1'b1;
                s.prot = 1'b0;
                s.emer = 1'b0;
                clr    = 1'b1;
                cmd0   = smms_pkg::DRV_RESTART;
                s      = go_to(s, MODE_IDLE);
            end
            smms_pkg::ACT_SET_ZERO:
            begin
                if (s.mode == MODE_IDLE)
                begin
                    acc  = 1'b1;
                    cmd0 = smms_pkg::DRV_SET_ZERO;
                end
            end
            smms_pkg::ACT_ENCODER:
            begin
                s.cur = op.pos;
                if (s.mode == MODE_MOVING &&
                    tgt_dist <= {{(smms_pkg::POS_W + 1 - smms_pkg::TIME_W){1'b0}},
                                 cfg.tolerance})
                begin
                    s = go_to(s, MODE_IDLE);
                end
                moved = (step_dist >= {{(smms_pkg::POS_W + 1 - smms_pkg::TIME_W){1'b0}},
                                       cfg.threshold});
            end
            smms_pkg::ACT_SPEED:
            begin
                s.speed = op.speed;
                if (s.mode == MODE_STOPPING && op.speed == '0)
                begin
                    s = go_to(s, MODE_IDLE);
                end
                spd_chg = (op.speed != st_reg.speed);
            end
            smms_pkg::ACT_STATUS:
            begin
                stat_chg = (op.flag != s.run);
                s.run    = op.flag;
            end
            smms_pkg::ACT_PROTECT:
            begin
                s.prot = op.flag;
                if (op.flag && !st_reg.prot)
                begin
                    prot_evt = 1'b1;
                    clr      = (s.mode != MODE_ERROR);
                    s        = go_to(s, MODE_ERROR);
                end
            end
            smms_pkg::ACT_XPORT:
            begin
                if (op.flag)
                begin
                    clr = (s.mode != MODE_ERROR);
                    s   = go_to(s, MODE_ERROR);
                end
            end
            default: ;
        endcase

        st_next = s;

        first_res.mode             = s.mode;
        first_res.accepted         = acc;
        first_res.drive_command    = cmd0;
        first_res.clear_queue      = clr;
        first_res.position_moved   = moved;
        first_res.speed_changed    = spd_chg;
        first_res.status_changed   = stat_chg;
        first_res.motor_running    = s.run;
        first_res.protection_event = prot_evt;
        first_res.last             = !two_res;

        second_res.mode             = s.mode;
        second_res.accepted         = acc;
        second_res.drive_command    = cmd1;
        second_res.clear_queue      = 1'b0;
        second_res.position_moved   = 1'b0;
        second_res.speed_changed    = 1'b0;
        second_res.status_changed   = 1'b0;
        second_res.motor_running    = s.run;
        second_res.protection_event = 1'b0;
        second_res.last             = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode    <= MODE_DISABLED;
            st_reg.elapsed <= '0;
            st_reg.target  <= '0;
            st_reg.cur     <= '0;
            st_reg.speed   <= '0;
            st_reg.run     <= 1'b0;
            st_reg.prot    <= 1'b0;
            st_reg.emer    <= 1'b0;
            st_reg.dbuf    <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (pend_valid_reg && slot_free)
        begin
            // Hand out the second result of a two-result item
            out_reg        <= pend_reg;
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            st_reg         <= st_next;
            out_reg        <= first_res;
            out_valid_reg  <= 1'b1;
            pend_reg       <= second_res;
            pend_valid_reg <= two_res;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result_ch.valid            = out_valid_reg;
    assign result_ch.mode             = out_reg.mode;
    assign result_ch.accepted         = out_reg.accepted;
    assign result_ch.drive_command    = out_reg.drive_command;
    assign result_ch.clear_queue      = out_reg.clear_queue;
    assign result_ch.position_moved   = out_reg.position_moved;
    assign result_ch.speed_changed    = out_reg.speed_changed;
    assign result_ch.status_changed   = out_reg.status_changed;
    assign result_ch.motor_running    = out_reg.motor_running;
    assign result_ch.protection_event = out_reg.protection_event;
    assign result_ch.last             = out_reg.last;

endmodule

`default_nettype wire

// File: design/stepper_motion_mode_sequencer_top.sv
// ----------------------------------------------------------------------------
// stepper_motion_mode_sequencer_top
// Seven-mode motion sequencer for a stepper drive.
// ----------------------------------------------------------------------------
// Requests arrive on event_ch: user commands, millisecond ticks and drive
// reports. Each request yields one result on result_ch, two for an emergency
// stop and for an accepted virtual home, with last set on the final one.
// A request is classified at the front, held in a two-entry queue and then
// executed by the back end, which writes the first result to the output
// register; a second result waits in a pending register until the output
// register is free. The block thus delivers one result per cycle while
// result_ch is ready; a two-result request holds off the next request until
// its second result has moved to the output register. The first result
// passes through the queue entry and the output register before it is
// presented on result_ch. Timeout, tolerance, report threshold and homing
// mode registers sit on the APB port at byte addresses 0x00..0x14, four
// bytes apart; write them only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_motion_mode_sequencer_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    smms_event_if.sink                       event_ch,
    smms_result_if.source                    result_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [smms_pkg::ADDR_W-1:0] paddr,
    input  wire logic [smms_pkg::DATA_W-1:0] pwdata,
    output logic      [smms_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    smms_pkg::smms_cfg_t cfg;

    // Front to queue
    logic               push_valid;
    logic               push_ready;
    smms_pkg::smms_op_t push_op;

    // Queue to back end
    logic               pop_valid;
    logic               pop_ready;
    smms_pkg::smms_op_t pop_op;

    // Hold the configuration registers
    smms_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Classify requests: pick the position that matters, fold error bits
    smms_front u_front (
        .event_ch   (event_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    // Decouple acceptance from execution so either side may stall alone
    smms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // Advance the mode, apply timeouts and emit drive command codes
    smms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .op_valid  (pop_valid),
        .op_ready  (pop_ready),
        .op        (pop_op),
        .result_ch (result_ch)
    );

endmodule

`default_nettype wire

// File: tb/smms_mode_checker.sv
// ----------------------------------------------------------------------------
// smms_mode_checker
// Watches the request, result and register ports of the motion sequencer,
// predicts every result from its own copy of the mode state and compares.
// ----------------------------------------------------------------------------
module smms_mode_checker
    import smms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    smms_event_if               event_ch,
    smms_result_if              result_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                pready,
    output int                  fail_count,
    output int                  open_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        MODE_DISABLED = 3'd0,
        MODE_IDLE     = 3'd1,
        MODE_MOVING   = 3'd2,
        MODE_RUNNING  = 3'd3,
        MODE_HOMING   = 3'd4,
        MODE_STOPPING = 3'd5,
        MODE_ERROR    = 3'd6
    } drive_mode_t;

    localparam logic [TICK_W-1:0] TICKS_SAT = '1;

    // Mirrored block state
    smms_cfg_t                  cfg;
    drive_mode_t                mode_q;
    logic [TICK_W-1:0]          ticks_in_mode;
    logic signed [POS_W-1:0]    target_steps;
    logic signed [POS_W-1:0]    position_steps;
    logic signed [SPEED_W-1:0]  last_spd;
    logic                       running_q;
    logic                       protect_q;
    logic                       estop_q;
    logic                       disable_pending;

    // Outcome of the request being predicted
    logic       r_accept, r_clear, r_moved, r_speed, r_status, r_protect;
    smms_drv_t  r_cmd [2];
    int         r_ncmd;

    smms_res_t  expected_q[$];
    smms_res_t  seen;
    smms_res_t  want;

    initial fail_count = 0;

    function automatic void change_mode(drive_mode_t m, logic clear_on_error);
        if (m != mode_q)
        begin
            mode_q = m;
            ticks_in_mode = '0;
            if (m == MODE_IDLE)
                target_steps = position_steps;
            if (m == MODE_ERROR && clear_on_error)
                r_clear = 1'b1;
        end
    endfunction

    function automatic void issue(smms_drv_t code);
        if (r_ncmd < 2)
        begin
            r_cmd[r_ncmd] = code;
            r_ncmd++;
        end
    endfunction

    function automatic logic in_motion();
        return mode_q inside {MODE_MOVING, MODE_RUNNING, MODE_HOMING, MODE_STOPPING};
    endfunction

    function automatic void stop_motion();
        if (mode_q == MODE_IDLE)
        begin
            r_accept = 1'b1;
        end
        else if (in_motion())
        begin
            r_accept = 1'b1;
            issue(DRV_STOP);
            change_mode(MODE_STOPPING, 1'b1);
        end
    endfunction

    function automatic longint unsigned distance(longint a, longint b);
        return (a > b) ? longint'(a - b) : longint'(b - a);
    endfunction

    // Apply one request to the mirrored state and queue its results
    function automatic void predict_request(
        smms_act_t act, logic signed [POS_W-1:0] tpos, logic signed [POS_W-1:0] mpos,
        logic signed [SPEED_W-1:0] spd, logic flag, logic ekind, logic crit);
        logic signed [POS_W-1:0]   old_pos;
        logic signed [SPEED_W-1:0] prior_spd;
        logic                      old_protect;
        int                        n;
        smms_res_t                 e;

        r_accept = 1'b0;
        r_clear = 1'b0;
        r_moved = 1'b0;
        r_speed = 1'b0;
        r_status = 1'b0;
        r_protect = 1'b0;
        r_ncmd = 0;

        case (act)
            ACT_TICK:
            begin
                if (ticks_in_mode != TICKS_SAT)
                    ticks_in_mode++;
                if (mode_q == MODE_MOVING && ticks_in_mode > cfg.move_timeout)
                    change_mode(MODE_ERROR, 1'b1);
                else if (mode_q == MODE_HOMING && ticks_in_mode > cfg.homing_timeout)
                    change_mode(MODE_ERROR, 1'b1);
                else if (mode_q == MODE_STOPPING && ticks_in_mode > cfg.stop_timeout)
                    change_mode(MODE_IDLE, 1'b1);
                if (disable_pending && mode_q == MODE_IDLE)
                begin
                    disable_pending = 1'b0;
                    issue(DRV_DISABLE);
                    change_mode(MODE_DISABLED, 1'b1);
                end
            end
            ACT_ENABLE:
            begin
                if (mode_q == MODE_DISABLED)
                begin
                    r_accept = 1'b1;
                    issue(DRV_ENABLE);
                    change_mode(MODE_IDLE, 1'b1);
                end
            end
            ACT_DISABLE:
            begin
                if (in_motion())
                begin
                    disable_pending = 1'b1;
                    stop_motion();
                end
                else if (mode_q == MODE_IDLE || mode_q == MODE_ERROR)
                begin
                    r_accept = 1'b1;
                    issue(DRV_DISABLE);
                    change_mode(MODE_DISABLED, 1'b1);
                end
            end
            ACT_MOVE:
            begin
                if (mode_q inside {MODE_IDLE, MODE_MOVING, MODE_STOPPING})
                begin
                    r_accept = 1'b1;
                    target_steps = tpos;
                    issue(DRV_MOVE);
                    if (mode_q == MODE_IDLE)
                        change_mode(MODE_MOVING, 1'b1);
                end
            end
            ACT_STOP: stop_motion();
            ACT_ESTOP:
            begin
                r_accept = 1'b1;
                estop_q = 1'b1;
                r_clear = 1'b1;
                issue(DRV_ESTOP);
                issue(DRV_DISABLE);
                change_mode(MODE_ERROR, 1'b0);
            end
            ACT_HOME:
            begin
                if (mode_q == MODE_IDLE && cfg.homing_mode == HOMING_VIRTUAL)
                begin
                    r_accept = 1'b1;
                    issue(DRV_ZERO);
                    issue(DRV_RESTART);
                    change_mode(MODE_HOMING, 1'b1);
                end
            end
            ACT_RUN:
            begin
                if (mode_q == MODE_IDLE || mode_q == MODE_RUNNING)
                begin
                    r_accept = 1'b1;
                    issue(DRV_RUN);
                    change_mode(MODE_RUNNING, 1'b1);
                end
            end
            ACT_RELEASE:
            begin
                if (mode_q inside {MODE_ERROR, MODE_IDLE, MODE_DISABLED})
                begin
                    r_accept = 1'b1;
                    if (protect_q || estop_q)
                    begin
                        protect_q = 1'b0;
                        estop_q = 1'b0;
                        issue(DRV_RELEASE);
                        if (mode_q == MODE_ERROR)
                            change_mode(MODE_IDLE, 1'b1);
                    end
                end
            end
            ACT_RESTART:
            begin
                r_accept = 1'b1;
                protect_q = 1'b0;
                estop_q = 1'b0;
                r_clear = 1'b1;
                issue(DRV_RESTART);
                change_mode(MODE_IDLE, 1'b1);
            end
            ACT_SET_ZERO:
            begin
                if (mode_q == MODE_IDLE)
                begin
                    r_accept = 1'b1;
                    issue(DRV_SET_ZERO);
                end
            end
            ACT_ENCODER:
            begin
                old_pos = position_steps;
                position_steps = mpos;
                if (mode_q == MODE_MOVING &&
                    distance(position_steps, target_steps) <= cfg.tolerance)
                    change_mode(MODE_IDLE, 1'b1);
                if (distance(position_steps, old_pos) >= cfg.threshold)
                    r_moved = 1'b1;
            end
            ACT_SPEED:
            begin
                prior_spd = last_spd;
                last_spd = spd;
                if (mode_q == MODE_STOPPING && spd == 0)
                    change_mode(MODE_IDLE, 1'b1);
                r_speed = (spd != prior_spd);
            end
            ACT_STATUS:
            begin
                r_status = (flag != running_q);
                running_q = flag;
            end
            ACT_PROTECT:
            begin
                old_protect = protect_q;
                protect_q = flag;
                if (flag && !old_protect)
                begin
                    r_protect = 1'b1;
                    change_mode(MODE_ERROR, 1'b1);
                end
            end
            default:
            begin
                // transport error: device errors always fault, timeouts only
                // when the lost command mattered
                if (ekind || crit)
                    change_mode(MODE_ERROR, 1'b1);
            end
        endcase

        n = (r_ncmd > 1) ? r_ncmd : 1;
        for (int k = 0; k < n; k++)
        begin
            e.mode = mode_q;
            e.accepted = r_accept;
            e.drive_command = (k < r_ncmd) ? r_cmd[k] : DRV_NONE;
            e.clear_queue = (k == 0) ? r_clear : 1'b0;
            e.position_moved = (k == 0) ? r_moved : 1'b0;
            e.speed_changed = (k == 0) ? r_speed : 1'b0;
            e.status_changed = (k == 0) ? r_status : 1'b0;
            e.motor_running = running_q;
            e.protection_event = (k == 0) ? r_protect : 1'b0;
            e.last = (k == n - 1);
            expected_q.push_back(e);
        end
    endfunction

    function automatic void check_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.move_timeout = MOVE_TIMEOUT_RST;
            cfg.homing_timeout = HOMING_TIMEOUT_RST;
            cfg.stop_timeout = STOP_TIMEOUT_RST;
            cfg.tolerance = TOLERANCE_RST;
            cfg.threshold = THRESHOLD_RST;
            cfg.homing_mode = HOMING_MODE_RST;
            mode_q = MODE_DISABLED;
            ticks_in_mode = '0;
            target_steps = '0;
            position_steps = '0;
            last_spd = '0;
            running_q = 1'b0;
            protect_q = 1'b0;
            estop_q = 1'b0;
            disable_pending = 1'b0;
            expected_q.delete();
            open_results = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (smms_reg_t'(paddr[4:2]))
                    REG_MOVE_TIMEOUT:   cfg.move_timeout = pwdata[TIME_W-1:0];
                    REG_HOMING_TIMEOUT: cfg.homing_timeout = pwdata[TIME_W-1:0];
                    REG_STOP_TIMEOUT:   cfg.stop_timeout = pwdata[TIME_W-1:0];
                    REG_TOLERANCE:      cfg.tolerance = pwdata[TIME_W-1:0];
                    REG_THRESHOLD:      cfg.threshold = pwdata[TIME_W-1:0];
                    REG_HOMING_MODE:    cfg.homing_mode = pwdata[1:0];
                    default: ;
                endcase
            end

            if (event_ch.valid && event_ch.ready)
                predict_request(smms_act_t'(event_ch.action), event_ch.target_position,
                                event_ch.measured_position, event_ch.measured_speed,
                                event_ch.report_flag, event_ch.error_kind,
                                event_ch.critical_command);

            if (result_ch.valid && result_ch.ready)
            begin
                seen.mode = result_ch.mode;
                seen.accepted = result_ch.accepted;
                seen.drive_command = smms_drv_t'(result_ch.drive_command);
                seen.clear_queue = result_ch.clear_queue;
                seen.position_moved = result_ch.position_moved;
                seen.speed_changed = result_ch.speed_changed;
                seen.status_changed = result_ch.status_changed;
                seen.motor_running = result_ch.motor_running;
                seen.protection_event = result_ch.protection_event;
                seen.last = result_ch.last;
                if (expected_q.size() == 0)
                begin
                    $error("result with no request outstanding: mode %0d, drive_command %0d",
                           seen.mode, seen.drive_command);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("mode", want.mode, seen.mode);
                    check_field("accepted", want.accepted, seen.accepted);
                    check_field("drive_command", want.drive_command, seen.drive_command);
                    check_field("clear_queue", want.clear_queue, seen.clear_queue);
                    check_field("position_moved", want.position_moved, seen.position_moved);
                    check_field("speed_changed", want.speed_changed, seen.speed_changed);
                    check_field("status_changed", want.status_changed, seen.status_changed);
                    check_field("motor_running", want.motor_running, seen.motor_running);
                    check_field("protection_event", want.protection_event,
                                seen.protection_event);
                    check_field("last", want.last, seen.last);
                end
            end
            open_results = expected_q.size();
        end
    end

endmodule

// File: tb/stepper_motion_mode_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// stepper_motion_mode_sequencer_top_tb
// Drives commands, ticks and drive reports into the motion sequencer and
// reports the verdict of the checker that sits beside it.
// ----------------------------------------------------------------------------
// A short directed pass walks the modes under the reset register values,
// then four random phases run under different register settings, with three
// idling patterns across them on both channels. Random requests come in scenarios
// (move, home, run, fault, noise) so that most traffic gets past idle.
// ----------------------------------------------------------------------------
module stepper_motion_mode_sequencer_top_tb;
    import smms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int PHASE_REQS    = 313;
    localparam int DRAIN_CYCLES  = 8;

    typedef enum int {
        SCN_MOVE,
        SCN_HOME,
        SCN_RUN,
        SCN_FAULT,
        SCN_NOISE
    } scenario_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 fail_count;
    int                 open_results;
    int                 cycle_count = 0;
    int                 reqs_sent = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    // Positions last sent, used to aim encoder reports near the target
    int                 aim_target = 0;
    int                 aim_encoder = 0;

    smms_event_if  ev_ch ();
    smms_result_if res_ch ();

    stepper_motion_mode_sequencer_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .event_ch (ev_ch),
        .result_ch(res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    smms_mode_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_ch    (ev_ch),
        .result_ch   (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .open_results(open_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("stepper_motion_mode_sequencer_top verification failed");
            $finish;
        end
    end

    // Result side: stall at random, one ready update per edge
    always @(posedge clk)
    begin
        if (rst_n)
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one request and hold it until accepted; valid stays high
    // afterwards so back-to-back requests never lower it within a step.
    task automatic send_request(
        input smms_act_t                 act,
        input logic signed [POS_W-1:0]   tpos = '0,
        input logic signed [POS_W-1:0]   mpos = '0,
        input logic signed [SPEED_W-1:0] spd = '0,
        input logic                      flag = 1'b0,
        input logic                      ekind = 1'b0,
        input logic                      crit = 1'b0);
        if ($urandom_range(99) < send_idle_pct)
        begin
            ev_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        ev_ch.valid             <= 1'b1;
        ev_ch.action            <= act;
        ev_ch.target_position   <= tpos;
        ev_ch.measured_position <= mpos;
        ev_ch.measured_speed    <= spd;
        ev_ch.report_flag       <= flag;
        ev_ch.error_kind        <= ekind;
        ev_ch.critical_command  <= crit;
        @(posedge clk);
        while (!ev_ch.ready)
            @(posedge clk);
        reqs_sent++;
    endtask

    // Fill every field at random, biased toward positions that finish moves
    task automatic send_random(input smms_act_t act);
        int tpos;
        int mpos;
        int spd;
        int pick;

        pick = $urandom_range(7);
        if (pick == 0)
            tpos = $urandom;
        else
            tpos = aim_encoder + int'($urandom_range(600)) - 300;

        pick = $urandom_range(7);
        if (pick == 0)
            mpos = $urandom;
        else if (pick <= 4)
            mpos = aim_target + int'($urandom_range(40)) - 20;
        else
            mpos = aim_encoder + int'($urandom_range(60)) - 30;

        pick = $urandom_range(3);
        if (pick == 0)
            spd = 0;
        else if (pick == 1)
            spd = int'($urandom_range(16'hFFFF));
        else
            spd = int'($urandom_range(200)) - 100;

        if (act == ACT_MOVE)
            aim_target = tpos;
        if (act == ACT_ENCODER)
            aim_encoder = mpos;

        send_request(act, tpos, mpos, spd[SPEED_W-1:0], 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    function automatic smms_act_t body_action(input scenario_t scn);
        smms_act_t act;
        case (scn)
            SCN_MOVE:
                case ($urandom_range(9))
                    0, 1, 2: act = ACT_ENCODER;
                    3, 4:    act = ACT_TICK;
                    5:       act = ACT_MOVE;
                    6:       act = ACT_STOP;
                    7:       act = ACT_SPEED;
                    8:       act = ACT_SET_ZERO;
                    default: act = ACT_DISABLE;
                endcase
            SCN_HOME:
                case ($urandom_range(7))
                    0, 1, 2: act = ACT_TICK;
                    3:       act = ACT_ENCODER;
                    4:       act = ACT_STOP;
                    5:       act = ACT_DISABLE;
                    6:       act = ACT_SPEED;
                    default: act = ACT_HOME;
                endcase
            SCN_RUN:
                case ($urandom_range(7))
                    0:       act = ACT_RUN;
                    1:       act = ACT_STOP;
                    2, 3:    act = ACT_SPEED;
                    4, 5:    act = ACT_TICK;
                    6:       act = ACT_STATUS;
                    default: act = ACT_DISABLE;
                endcase
            SCN_FAULT:
                case ($urandom_range(9))
                    0:       act = ACT_ESTOP;
                    1, 2:    act = ACT_RELEASE;
                    3:       act = ACT_PROTECT;
                    4, 5:    act = ACT_XPORT;
                    6:       act = ACT_RESTART;
                    7:       act = ACT_DISABLE;
                    8:       act = ACT_ENABLE;
                    default: act = ACT_STATUS;
                endcase
            default:
                act = smms_act_t'($urandom_range(15));
        endcase
        return act;
    endfunction

    // One scenario: usually bring the mode to idle, open with the command
    // that starts the motion (move, home or run), then a random tail. Ticks come in bursts so
    // the short timeouts actually expire.
    task automatic run_scenario();
        scenario_t scn;
        smms_act_t act;
        int        body_len;

        scn = scenario_t'($urandom_range(4));
        if ($urandom_range(3) != 0)
            send_random(($urandom_range(3) != 0) ? ACT_RESTART : ACT_ENABLE);
        case (scn)
            SCN_MOVE: send_random(ACT_MOVE);
            SCN_HOME: send_random(ACT_HOME);
            SCN_RUN:  send_random(ACT_RUN);
            default: ;
        endcase
        body_len = $urandom_range(2, 10);
        for (int i = 0; i < body_len; i++)
        begin
            act = body_action(scn);
            if (act == ACT_TICK)
                repeat ($urandom_range(1, 6))
                    send_random(ACT_TICK);
            else
                send_random(act);
        end
    endtask

    task automatic write_reg(input smms_reg_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(input int move_to, input int home_to, input int stop_to,
                                input int tol, input int thr, input int hmode);
        write_reg(REG_MOVE_TIMEOUT, move_to);
        write_reg(REG_HOMING_TIMEOUT, home_to);
        write_reg(REG_STOP_TIMEOUT, stop_to);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_HOMING_MODE, hmode);
    endtask

    // Drop valid and wait until every predicted result has come back, then
    // wait extra further edges so nothing is still in flight
    task automatic drain(input int extra);
        ev_ch.valid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    initial
    begin
        int phase_end;

        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        ev_ch.valid             = 1'b0;
        ev_ch.action            = ACT_TICK;
        ev_ch.target_position   = '0;
        ev_ch.measured_position = '0;
        ev_ch.measured_speed    = '0;
        ev_ch.report_flag       = 1'b0;
        ev_ch.error_kind        = 1'b0;
        ev_ch.critical_command  = 1'b0;
        res_ch.ready            = 1'b0;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk under reset register values (tolerance 5,
        // threshold 10, virtual homing)
        send_idle_pct = 12;
        recv_idle_pct = 76;
        send_request(ACT_TICK);
        send_request(ACT_RELEASE);                       // nothing active while disabled
        send_request(ACT_STOP);                          // rejected while disabled
        send_request(ACT_ENABLE);
        send_request(ACT_STOP);                          // stop while idle: no drive code
        send_request(ACT_SET_ZERO);
        send_request(ACT_MOVE, 32'sh7FFF_FFFF);
        send_request(ACT_MOVE, 32'sd100);                // retarget while moving
        send_request(ACT_ENCODER, '0, 32'sd97);          // within tolerance: back to idle
        send_request(ACT_RUN);
        send_request(ACT_SPEED, '0, '0, 16'sh7FFF);
        send_request(ACT_STOP);
        send_request(ACT_MOVE, 32'sd500);                // move while stopping stays stopping
        send_request(ACT_SPEED, '0, '0, -16'sd32768);
        send_request(ACT_SPEED, '0, '0, 16'sd0);         // standstill ends the stop
        send_request(ACT_HOME);                          // zero mode then restart
        send_request(ACT_DISABLE);                       // buffered during motion
        send_request(ACT_SPEED, '0, '0, 16'sd0);
        send_request(ACT_TICK);                          // buffered disable fires now
        send_request(ACT_STATUS, '0, '0, '0, 1'b1);
        send_request(ACT_ENABLE);
        send_request(ACT_PROTECT, '0, '0, '0, 1'b1);
        send_request(ACT_RELEASE);
        send_request(ACT_XPORT, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        send_request(ACT_XPORT, '0, '0, '0, 1'b0, 1'b0, 1'b1);
        send_request(ACT_ESTOP);
        send_request(ACT_RESTART);
        send_request(ACT_ENCODER, '0, 32'sh8000_0000);
        send_request(ACT_ENCODER, '0, 32'sh7FFF_FFFF);
        send_request(ACT_XPORT, '0, '0, '0, 1'b0, 1'b1, 1'b0);
        drain(4);

        // Random phases: each with its own registers and idling pattern
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 76;
                    program_regs(6, 9, 4, 5, 10, 0);
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_idle_pct = 12;
                    program_regs(16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    program_regs(0, 3, 0, 0, 1, 3);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    program_regs(12, 16'hFFFF, 7, 20, 100, 2);
                end
            endcase
            phase_end = reqs_sent + PHASE_REQS;
            while (reqs_sent < phase_end)
                run_scenario();
            drain(4);
        end

        drain(DRAIN_CYCLES);
        if (fail_count == 0)
            $display("stepper_motion_mode_sequencer_top verification clean");
        else
            $display("stepper_motion_mode_sequencer_top verification failed");
        $finish;
    end

endmodule
